>>> design/usbctl_pkg.sv
// ----------------------------------------------------------------------------
// usbctl_pkg
// Shared types, codes and descriptor tables of the endpoint-0 control handler.
// ----------------------------------------------------------------------------
package usbctl_pkg;

  localparam int MAX_PACKET_DEFAULT = 64;

  // events seen on endpoint 0
  typedef enum logic [1:0] {
    OP_BUS_RESET = 2'd0,
    OP_SETUP     = 2'd1,
    OP_IN_DONE   = 2'd2,
    OP_OUT_DONE  = 2'd3
  } op_t;

  // answers to an event
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_STALL = 3'd1,
    ACT_ZLP   = 3'd2,
    ACT_DATA  = 3'd3,
    ACT_ARM   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_UNATTACHED = 2'd0,
    ST_DEFAULT    = 2'd1,
    ST_ADDRESSED  = 2'd2,
    ST_CONFIGURED = 2'd3
  } dev_state_t;

  // where reply bytes come from
  typedef enum logic [1:0] {
    SRC_DEV   = 2'd0,
    SRC_CFG   = 2'd1,
    SRC_BYTE0 = 2'd2
  } reply_src_t;

  // request codes: high byte bRequest, low byte bmRequestType
  localparam logic [15:0] RQ_GET_STATUS     = 16'h0080;
  localparam logic [15:0] RQ_GET_STATUS_IF  = 16'h0081;
  localparam logic [15:0] RQ_GET_STATUS_EP  = 16'h0082;
  localparam logic [15:0] RQ_CLR_FEATURE_EP = 16'h0102;
  localparam logic [15:0] RQ_SET_FEATURE_EP = 16'h0302;
  localparam logic [15:0] RQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] RQ_GET_DESCRIPTOR = 16'h0680;
  localparam logic [15:0] RQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] RQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] RQ_GET_INTERFACE  = 16'h0A81;
  localparam logic [15:0] RQ_SET_INTERFACE  = 16'h0B01;

  localparam logic [15:0] DESC_DEVICE = 16'h0100;
  localparam logic [15:0] DESC_CONFIG = 16'h0200;

  localparam int DEV_DESC_LEN = 18;
  localparam int CFG_DESC_LEN = 32;
  localparam int REPLY_MAX    = 64;

  localparam logic [6:0] SETUP_BYTES = 7'd8;
  localparam logic [3:0] BULK_EP_NUM = 4'd1;
  localparam logic [15:0] EP0_OUT    = 16'h0000;
  localparam logic [15:0] EP0_IN     = 16'h0080;
  localparam logic [15:0] EP1_OUT    = 16'h0001;
  localparam logic [15:0] EP1_IN     = 16'h0081;

  // device descriptor, byte 7 is the endpoint-0 packet size
  function automatic logic [7:0] dev_desc_byte(logic [5:0] i, logic [7:0] max_pkt);
    logic [7:0] b;
    case (i)
      6'd0:    b = 8'd18;
      6'd1:    b = 8'h01;
      6'd2:    b = 8'h00;
      6'd3:    b = 8'h02;
      6'd7:    b = max_pkt;
      6'd8:    b = 8'h83;
      6'd9:    b = 8'h04;
      6'd10:   b = 8'h22;
      6'd11:   b = 8'h57;
      6'd12:   b = 8'h00;
      6'd13:   b = 8'h02;
      6'd17:   b = 8'd1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // configuration, interface and two bulk endpoint descriptors
  function automatic logic [7:0] cfg_desc_byte(logic [5:0] i);
    logic [7:0] b;
    case (i)
      6'd0:    b = 8'd9;
      6'd1:    b = 8'h02;
      6'd2:    b = 8'd32;
      6'd4:    b = 8'd1;
      6'd5:    b = 8'd1;
      6'd7:    b = 8'h80;
      6'd8:    b = 8'd50;
      6'd9:    b = 8'd9;
      6'd10:   b = 8'h04;
      6'd13:   b = 8'd2;
      6'd14:   b = 8'h0A;
      6'd18:   b = 8'd7;
      6'd19:   b = 8'h05;
      6'd20:   b = 8'h01;
      6'd21:   b = 8'h02;
      6'd22:   b = 8'd64;
      6'd25:   b = 8'd7;
      6'd26:   b = 8'h05;
      6'd27:   b = 8'h81;
      6'd28:   b = 8'h02;
      6'd29:   b = 8'd64;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> design/usbctl_if.sv
// ----------------------------------------------------------------------------
// usbctl_evt_if / usbctl_rsp_if
// Valid/ready channels of the endpoint-0 control handler.
// ----------------------------------------------------------------------------
interface usbctl_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [6:0]  rx_count;
  logic [15:0] request_word;
  logic [15:0] value_word;
  logic [15:0] index_word;
  logic [15:0] length_word;

  modport source (output valid, op, rx_count, request_word, value_word, index_word,
                  length_word, input ready);
  modport sink   (input valid, op, rx_count, request_word, value_word, index_word,
                  length_word, output ready);
endinterface

interface usbctl_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] tx_count;
  logic [7:0] data_byte;
  logic       last;
  logic [1:0] device_state_out;
  logic [6:0] device_address_out;

  modport source (output valid, action, tx_count, data_byte, last, device_state_out,
                  device_address_out, input ready);
  modport sink   (input valid, action, tx_count, data_byte, last, device_state_out,
                  device_address_out, output ready);
endinterface

>>> design/usb_control_endpoint_handler.sv
// ----------------------------------------------------------------------------
// usb_control_endpoint_handler
// Endpoint-0 standard request handler: device state, address, halt flags,
// and the reply (stall, zero-length, descriptor bytes or status-out arm).
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake   | carries
//   --------+-----+-------------+------------------------------------------
//   evt     | in  | valid/ready | one endpoint-0 event (reset/setup/in/out)
//   rsp     | out | valid/ready | one result; a data reply is a run of bytes
//
// an accepted event is decided from the input register once the reply
// sequencer is free; state and the sequencer load at the deciding edge, and
// the output register carries the first result onto rsp; every event gives
// one result, except a data reply, which gives up to 32 bytes, one per cycle
// unless rsp stalls; the reply sequencer sets the rate, and a new event is
// decided in the cycle the last result of the previous one leaves it
// rst clears the device state, address, saved request, halt flags and all
// valid bits; a stalled rsp holds its item and backs up into evt.ready
// ----------------------------------------------------------------------------
module usb_control_endpoint_handler #(
  parameter int MAX_PACKET = usbctl_pkg::MAX_PACKET_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  usbctl_evt_if.sink   evt,
  usbctl_rsp_if.source rsp
);

  // reply cap: descriptor size, packet size and reply buffer, all constant
  localparam int PktCap = (MAX_PACKET < usbctl_pkg::REPLY_MAX) ?
                          MAX_PACKET : usbctl_pkg::REPLY_MAX;
  localparam int DevCap = (usbctl_pkg::DEV_DESC_LEN < PktCap) ?
                          usbctl_pkg::DEV_DESC_LEN : PktCap;
  localparam int CfgCap = (usbctl_pkg::CFG_DESC_LEN < PktCap) ?
                          usbctl_pkg::CFG_DESC_LEN : PktCap;
  localparam logic [7:0] MaxPktByte = 8'(MAX_PACKET);

  typedef struct packed {
    usbctl_pkg::op_t op;
    logic [6:0]      rx_count;
    logic [15:0]     request_word;
    logic [15:0]     value_word;
    logic [15:0]     index_word;
    logic [15:0]     length_word;
  } evt_t;

  // one decided event being played out as results
  typedef struct packed {
    usbctl_pkg::action_t    act;
    logic [6:0]             cnt;
    usbctl_pkg::reply_src_t src;
    logic                   b0;
    usbctl_pkg::dev_state_t state;
    logic [6:0]             addr;
  } job_t;

  // input register
  logic iq_valid;
  evt_t iq;

  // device state
  usbctl_pkg::dev_state_t device_state, device_state_next;
  logic [6:0]  device_address, device_address_next;
  logic [15:0] saved_request, saved_value, saved_length;
  logic        bulk_in_halted, bulk_out_halted;
  logic        bulk_in_halted_next, bulk_out_halted_next;
  logic        save_setup;

  // reply sequencer
  logic       job_valid;
  job_t       job;
  job_t       job_next;
  logic [5:0] job_idx;

  // output register
  logic                rsp_valid;
  usbctl_pkg::action_t rsp_action;
  logic [6:0]          rsp_tx_count;
  logic [7:0]          rsp_data_byte;
  logic                rsp_last;
  usbctl_pkg::dev_state_t rsp_state;
  logic [6:0]          rsp_addr;

  logic       rsp_free, emit, job_last_beat, job_free, decide;
  logic [7:0] job_byte;

  assign rsp_free      = !rsp_valid || rsp.ready;
  assign emit          = job_valid && rsp_free;
  assign job_last_beat = (job.act != usbctl_pkg::ACT_DATA) ||
                         (({1'b0, job_idx} + 7'd1) == job.cnt);
  assign job_free      = !job_valid || (emit && job_last_beat);
  assign decide        = iq_valid && job_free;
  assign evt.ready     = !iq_valid || decide;

  // decision: state update and the shape of the reply
  always_comb begin
    logic [15:0] rq, val, idx, len;
    logic        ok;
    logic [6:0]  n;
    logic [6:0]  new_addr;

    device_state_next    = device_state;
    device_address_next  = device_address;
    bulk_in_halted_next  = bulk_in_halted;
    bulk_out_halted_next = bulk_out_halted;
    save_setup           = 1'b0;
    ok                   = 1'b0;
    n                    = 7'd0;
    new_addr             = saved_value[6:0];
    rq                   = iq.request_word;
    val                  = iq.value_word;
    idx                  = iq.index_word;
    len                  = iq.length_word;
    job_next.act         = usbctl_pkg::ACT_NONE;
    job_next.cnt         = 7'd0;
    job_next.src         = usbctl_pkg::SRC_BYTE0;
    job_next.b0          = 1'b0;

    unique case (iq.op)
      usbctl_pkg::OP_BUS_RESET: begin
        device_state_next    = usbctl_pkg::ST_DEFAULT;
        device_address_next  = 7'd0;
        bulk_in_halted_next  = 1'b0;
        bulk_out_halted_next = 1'b0;
      end
      usbctl_pkg::OP_IN_DONE: begin
        if (saved_length == 16'd0) begin
          // address change lands after the status stage
          if (saved_request == usbctl_pkg::RQ_SET_ADDRESS) begin
            device_address_next = new_addr;
            device_state_next   = (new_addr == 7'd0) ? usbctl_pkg::ST_DEFAULT
                                                     : usbctl_pkg::ST_ADDRESSED;
          end
        end else begin
          job_next.act = usbctl_pkg::ACT_ARM;
        end
      end
      usbctl_pkg::OP_OUT_DONE: begin
        if (iq.rx_count != 7'd0) job_next.act = usbctl_pkg::ACT_STALL;
      end
      usbctl_pkg::OP_SETUP: begin
        if (iq.rx_count != usbctl_pkg::SETUP_BYTES) begin
          job_next.act = usbctl_pkg::ACT_STALL;
        end else if (len == 16'd0) begin
          save_setup = 1'b1;
          // no data stage: set-type requests
          unique case (rq)
            usbctl_pkg::RQ_SET_ADDRESS:
              ok = (device_state != usbctl_pkg::ST_CONFIGURED) &&
                   (val < 16'd128) && (idx == 16'd0);
            usbctl_pkg::RQ_SET_CONFIG: begin
              if (device_state == usbctl_pkg::ST_ADDRESSED) begin
                ok = (val == 16'd1) || (val == 16'd0);
                if (val == 16'd1) begin
                  device_state_next    = usbctl_pkg::ST_CONFIGURED;
                  bulk_in_halted_next  = 1'b0;
                  bulk_out_halted_next = 1'b0;
                end
              end else if (device_state == usbctl_pkg::ST_CONFIGURED) begin
                ok = (val == 16'd1) || (val == 16'd0);
                if (val == 16'd0) begin
                  device_state_next    = usbctl_pkg::ST_ADDRESSED;
                  bulk_in_halted_next  = 1'b0;
                  bulk_out_halted_next = 1'b0;
                end
              end
            end
            usbctl_pkg::RQ_SET_INTERFACE:
              ok = (device_state == usbctl_pkg::ST_CONFIGURED) && (idx == 16'd0);
            usbctl_pkg::RQ_CLR_FEATURE_EP, usbctl_pkg::RQ_SET_FEATURE_EP: begin
              ok = (device_state == usbctl_pkg::ST_CONFIGURED) &&
                   (idx[3:0] == usbctl_pkg::BULK_EP_NUM);
              if (ok) begin
                if (idx[7]) bulk_in_halted_next = (rq == usbctl_pkg::RQ_SET_FEATURE_EP);
                else        bulk_out_halted_next = (rq == usbctl_pkg::RQ_SET_FEATURE_EP);
              end
            end
            default: ok = 1'b0;
          endcase
          job_next.act = ok ? usbctl_pkg::ACT_ZLP : usbctl_pkg::ACT_STALL;
        end else begin
          save_setup = 1'b1;
          if (rq[7]) begin
            // device-to-host: get-type requests
            unique case (rq)
              usbctl_pkg::RQ_GET_DESCRIPTOR: begin
                if (idx == 16'd0 && val == usbctl_pkg::DESC_DEVICE) begin
                  job_next.src = usbctl_pkg::SRC_DEV;
                  n = (len < 16'(DevCap)) ? len[6:0] : 7'(DevCap);
                end else if (idx == 16'd0 && val == usbctl_pkg::DESC_CONFIG) begin
                  job_next.src = usbctl_pkg::SRC_CFG;
                  n = (len < 16'(CfgCap)) ? len[6:0] : 7'(CfgCap);
                end
              end
              usbctl_pkg::RQ_GET_STATUS, usbctl_pkg::RQ_GET_STATUS_IF: begin
                if (device_state != usbctl_pkg::ST_DEFAULT && val == 16'd0 &&
                    idx == 16'd0 && len == 16'd2) n = 7'd2;
              end
              usbctl_pkg::RQ_GET_STATUS_EP: begin
                if (device_state != usbctl_pkg::ST_DEFAULT && val == 16'd0 &&
                    len == 16'd2) begin
                  if (idx == usbctl_pkg::EP0_OUT || idx == usbctl_pkg::EP0_IN) begin
                    n = 7'd2;
                  end else if (idx == usbctl_pkg::EP1_OUT) begin
                    n = 7'd2;
                    job_next.b0 = bulk_out_halted;
                  end else if (idx == usbctl_pkg::EP1_IN) begin
                    n = 7'd2;
                    job_next.b0 = bulk_in_halted;
                  end
                end
              end
              usbctl_pkg::RQ_GET_CONFIG: begin
                if (device_state != usbctl_pkg::ST_DEFAULT && len == 16'd1) begin
                  n = 7'd1;
                  job_next.b0 = (device_state == usbctl_pkg::ST_CONFIGURED);
                end
              end
              usbctl_pkg::RQ_GET_INTERFACE: begin
                if (device_state == usbctl_pkg::ST_CONFIGURED && len == 16'd1) n = 7'd1;
              end
              default: n = 7'd0;
            endcase
          end
          if (n == 7'd0) begin
            job_next.act = usbctl_pkg::ACT_STALL;
          end else begin
            job_next.act = usbctl_pkg::ACT_DATA;
            job_next.cnt = n;
          end
        end
      end
      default: job_next.act = usbctl_pkg::ACT_NONE;
    endcase

    job_next.state = device_state_next;
    job_next.addr  = device_address_next;
  end

  // current reply byte
  always_comb begin
    unique case (job.src)
      usbctl_pkg::SRC_DEV:   job_byte = usbctl_pkg::dev_desc_byte(job_idx, MaxPktByte);
      usbctl_pkg::SRC_CFG:   job_byte = usbctl_pkg::cfg_desc_byte(job_idx);
      usbctl_pkg::SRC_BYTE0: job_byte = (job_idx == 6'd0) ? {7'd0, job.b0} : 8'd0;
      default:               job_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid        <= 1'b0;
      job_valid       <= 1'b0;
      job_idx         <= 6'd0;
      rsp_valid       <= 1'b0;
      device_state    <= usbctl_pkg::ST_UNATTACHED;
      device_address  <= 7'd0;
      saved_request   <= 16'd0;
      saved_value     <= 16'd0;
      saved_length    <= 16'd0;
      bulk_in_halted  <= 1'b0;
      bulk_out_halted <= 1'b0;
    end else begin
      // input register
      if (evt.ready) begin
        iq_valid <= evt.valid;
        if (evt.valid) begin
          iq.op           <= usbctl_pkg::op_t'(evt.op);
          iq.rx_count     <= evt.rx_count;
          iq.request_word <= evt.request_word;
          iq.value_word   <= evt.value_word;
          iq.index_word   <= evt.index_word;
          iq.length_word  <= evt.length_word;
        end
      end

      // decide and hand the event to the sequencer
      if (decide) begin
        device_state    <= device_state_next;
        device_address  <= device_address_next;
        bulk_in_halted  <= bulk_in_halted_next;
        bulk_out_halted <= bulk_out_halted_next;
        if (save_setup) begin
          saved_request <= iq.request_word;
          saved_value   <= iq.value_word;
          saved_length  <= iq.length_word;
        end
        job_valid <= 1'b1;
        job       <= job_next;
        job_idx   <= 6'd0;
      end else if (emit) begin
        if (job_last_beat) job_valid <= 1'b0;
        else               job_idx   <= job_idx + 6'd1;
      end

      // output register
      if (rsp_free) begin
        rsp_valid <= emit;
        if (emit) begin
          rsp_action    <= job.act;
          rsp_tx_count  <= job.cnt;
          rsp_data_byte <= (job.act == usbctl_pkg::ACT_DATA) ? job_byte : 8'd0;
          rsp_last      <= job_last_beat;
          rsp_state     <= job.state;
          rsp_addr      <= job.addr;
        end
      end
    end
  end

  assign rsp.valid              = rsp_valid;
  assign rsp.action             = rsp_action;
  assign rsp.tx_count           = rsp_tx_count;
  assign rsp.data_byte          = rsp_data_byte;
  assign rsp.last               = rsp_last;
  assign rsp.device_state_out   = rsp_state;
  assign rsp.device_address_out = rsp_addr;

endmodule

>>> design/usbctl_checker.sv
// ----------------------------------------------------------------------------
// usbctl_checker
// Port-level checks of the endpoint-0 control handler, bound to the top.
// ----------------------------------------------------------------------------
module usbctl_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] action,
  input logic [6:0] tx_count,
  input logic [7:0] data_byte,
  input logic       last
);

  // results other than data stand alone and carry no bytes
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && action != usbctl_pkg::ACT_DATA |->
      last && tx_count == 7'd0 && data_byte == 8'd0)
    else $error("non-data result not single or not empty");

  // data runs have a sane length
  a_data_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && action == usbctl_pkg::ACT_DATA |->
      tx_count != 7'd0 && tx_count <= 7'd64)
    else $error("data result with bad count");

  // a data run continues without a gap once a byte is taken
  a_run: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && action == usbctl_pkg::ACT_DATA && !last |=>
      rsp_valid && action == usbctl_pkg::ACT_DATA && tx_count == $past(tx_count))
    else $error("data run broken");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind usb_control_endpoint_handler usbctl_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .action    (rsp.action),
  .tx_count  (rsp.tx_count),
  .data_byte (rsp.data_byte),
  .last      (rsp.last)
);
